// ===== hdl/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the bitmap block allocator
// Item and result payloads, operation and register codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  // bitmap is held as words of eight used bits
  localparam int WORD_BITS = 8;
  localparam int BIT_SEL_W = 3;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_FIND  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_BSIZE  = 2'd1;
  localparam logic [1:0] CFG_BCOUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] release_address;
    logic [15:0] start_index;
  } item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic        result_valid;
    logic [8:0]  allocated_total;
  } result_t;

  typedef struct packed {
    logic load;
    logic sweep_step;
    logic cnt_zero;
    logic div_step;
    logic rd;
    logic scan_adv;
    logic take_hit;
    logic wr;
    logic pos_zero;
    logic mul;
    logic add;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       n_zero;
    logic       bs_zero;
    logic       sweep_last;
    logic       div_last;
    logic       idx_ok;
    logic       hit;
    logic       scan_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/bitmap_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator: next-fit fixed block allocator over a used bitmap
// Alloc, free, find-used and clear operations on MAX_BLOCKS blocks, one item
// at a time, with a registered result stage on the output side.
// ----------------------------------------------------------------------------
// Operations: alloc and find scan up to ceil(count/8)+1 bitmap words; free runs
//   the 32-step divider unless the block size is zero; clear sweeps every word.
// Items are taken one at a time; a new item is taken while a result waits.
// Reset: synchronous; a clearing pass over all ceil(MAX_BLOCKS/8) bitmap words
//   zeroes the bitmap RAM before the first item; config is taken always.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bba_pkg::item_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bba_pkg::result_t     out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [31:0]     cfg_data
);
  import bba_pkg::*;

  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic                 ram_we;
  logic [WA_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WA_W-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // the user must write registers only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORDS      (WORDS),
    .WA_W       (WA_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (WA_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== hdl/bba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// One-hot state machine that steps the datapath through the clearing sweep,
// the divide, the word-by-word bitmap scan and the result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t       cmd
);
  import bba_pkg::*;

  typedef enum logic [11:0] {
    S_SWEEP_RST = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_DISP      = 12'b000000000100,
    S_SWEEP_OP  = 12'b000000001000,
    S_DIV       = 12'b000000010000,
    S_FCHK      = 12'b000000100000,
    S_RD        = 12'b000001000000,
    S_CHK       = 12'b000010000000,
    S_WR        = 12'b000100000000,
    S_MUL       = 12'b001000000000,
    S_ADD       = 12'b010000000000,
    S_OUT       = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP_RST;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_SWEEP_RST: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.mode)
          MODE_FREE: state_next = stat.bs_zero ? S_OUT : S_DIV;
          MODE_CLEAR: begin
            cmd.cnt_zero = 1'b1;
            state_next   = S_SWEEP_OP;
          end
          default: begin
            if (stat.n_zero) begin
              cmd.pos_zero = (stat.mode == MODE_ALLOC);
              state_next   = S_OUT;
            end else begin
              state_next = S_RD;
            end
          end
        endcase
      end
      S_SWEEP_OP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_FCHK;
      end
      S_FCHK: begin
        state_next = stat.idx_ok ? S_RD : S_OUT;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = (stat.mode == MODE_FIND) ? S_MUL : S_WR;
        end else if (stat.mode == MODE_FREE) begin
          state_next = S_OUT;
        end else if (stat.scan_last) begin
          // nothing found anywhere: an alloc restarts from block zero
          cmd.pos_zero = (stat.mode == MODE_ALLOC);
          state_next   = S_OUT;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_RD;
        end
      end
      S_WR: begin
        cmd.wr     = 1'b1;
        state_next = (stat.mode == MODE_FREE) ? S_OUT : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_SWEEP_RST;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in progress");
`endif

endmodule
`default_nettype wire

// ===== hdl/bba_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_dp: allocator datapath
// Configuration registers, restoring divider, bitmap word scan with lowest-bit
// pick, read-modify-write of the bitmap, address multiply-add, result register.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORDS = (MAX_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS,
  parameter int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bba_pkg::dp_cmd_t              cmd,
  output bba_pkg::dp_stat_t                  stat,
  input  wire bba_pkg::item_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bba_pkg::result_t                   out_data,
  input  wire logic                          cfg_valid,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  output logic                               ram_we,
  output logic [WA_W-1:0]                    ram_waddr,
  output logic [bba_pkg::WORD_BITS-1:0]      ram_wdata,
  output logic                               ram_re,
  output logic [WA_W-1:0]                    ram_raddr,
  input  wire logic [bba_pkg::WORD_BITS-1:0] ram_rdata
);
  import bba_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int BI_W  = $clog2(MAX_BLOCKS);
  localparam int CMP_W = 17;

  logic [31:0] base_address;
  logic [15:0] block_size;
  logic [8:0]  block_count;

  logic [1:0]           mode_r;
  logic [15:0]          from_r;
  logic [WA_W-1:0]      scan_word;
  logic                 phase;
  logic [WA_W-1:0]      sweep_ctr;
  logic [31:0]          div_q;
  logic [15:0]          div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [WA_W-1:0]      hit_word;
  logic [BIT_SEL_W-1:0] hit_bit;
  logic [WORD_BITS-1:0] hit_data;
  logic [15:0]          hit_idx;
  logic [31:0]          prod;
  logic [31:0]          res_addr;
  logic                 res_valid;
  logic [CNT_W-1:0]     alloc_cnt;
  logic [BI_W-1:0]      search_pos;

  logic [CMP_W-1:0]     live_n;
  logic [CMP_W-1:0]     from17;
  logic [WA_W-1:0]      from_word;
  logic [WA_W-1:0]      last_word;
  logic [15:0]          from_load;
  logic [CMP_W-1:0]     rem_sh;
  logic [CMP_W-1:0]     rem_diff;
  logic                 rem_ge;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] cand;
  logic [CMP_W-1:0]     bit_idx;
  logic                 hit;
  logic [BIT_SEL_W-1:0] hit_b;
  logic [WORD_BITS-1:0] bit_onehot;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 32'd0;
      block_size   <= 16'd1;
      block_count  <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE:   base_address <= cfg_data;
        CFG_BSIZE:  block_size   <= cfg_data[15:0];
        CFG_BCOUNT: block_count  <= cfg_data[8:0];
        default:    ;
      endcase
    end
  end

  assign live_n = (CMP_W'(block_count) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                              : CMP_W'(block_count);
  assign from17    = CMP_W'(from_r);
  assign from_word = WA_W'(from_r >> BIT_SEL_W);
  assign last_word = WA_W'((live_n - CMP_W'(1)) >> BIT_SEL_W);

  always_comb begin
    if (in_data.mode == MODE_ALLOC) begin
      from_load = (CMP_W'(search_pos) < live_n) ? 16'(search_pos) : 16'd0;
    end else begin
      from_load = (CMP_W'(in_data.start_index) < live_n) ? in_data.start_index : 16'd0;
    end
  end

  // item, scan position and divider
  assign rem_sh   = {div_rem, div_q[31]};
  assign rem_diff = rem_sh - {1'b0, block_size};
  assign rem_ge   = (rem_sh >= {1'b0, block_size});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_data.mode;
      from_r    <= from_load;
      scan_word <= WA_W'(from_load >> BIT_SEL_W);
      phase     <= 1'b0;
      div_q     <= in_data.release_address - base_address;
      div_rem   <= 16'd0;
      div_cnt   <= '0;
    end else begin
      if (cmd.scan_adv) begin
        if (!phase && scan_word == last_word) begin
          phase     <= 1'b1;
          scan_word <= '0;
        end else begin
          scan_word <= scan_word + WA_W'(1);
        end
      end
      if (cmd.div_step) begin
        div_rem <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
        div_q   <= {div_q[30:0], rem_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ctr <= '0;
    end else if (cmd.sweep_step) begin
      sweep_ctr <= (sweep_ctr == WA_W'(WORDS - 1)) ? '0 : sweep_ctr + WA_W'(1);
    end
  end

  // bitmap word read and lowest-candidate pick
  assign ram_re    = cmd.rd;
  assign ram_raddr = (mode_r == MODE_FREE) ? WA_W'(div_q[15:0] >> BIT_SEL_W) : scan_word;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      bit_idx = (CMP_W'(ram_raddr) << BIT_SEL_W) | CMP_W'(b);
      if (mode_r == MODE_FREE) begin
        sel[b] = (div_q[BIT_SEL_W-1:0] == BIT_SEL_W'(b));
      end else if (!phase) begin
        sel[b] = (bit_idx >= from17) && (bit_idx < live_n);
      end else begin
        sel[b] = (bit_idx < from17);
      end
    end
    cand = ((mode_r == MODE_ALLOC) ? ~ram_rdata : ram_rdata) & sel;
    hit   = 1'b0;
    hit_b = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit   = 1'b1;
        hit_b = BIT_SEL_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      hit_word <= ram_raddr;
      hit_bit  <= hit_b;
      hit_data <= ram_rdata;
      hit_idx  <= (16'(ram_raddr) << BIT_SEL_W) | 16'(hit_b);
    end
  end

  // write back: zero words during a sweep, else the modified hit word
  assign bit_onehot = WORD_BITS'(1) << hit_bit;
  assign ram_we     = cmd.sweep_step | cmd.wr;
  assign ram_waddr  = cmd.sweep_step ? sweep_ctr : hit_word;
  always_comb begin
    if (cmd.sweep_step) begin
      ram_wdata = '0;
    end else if (mode_r == MODE_ALLOC) begin
      ram_wdata = hit_data | bit_onehot;
    end else begin
      ram_wdata = hit_data & ~bit_onehot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_cnt  <= '0;
      search_pos <= '0;
    end else begin
      if (cmd.cnt_zero) begin
        alloc_cnt <= '0;
      end else if (cmd.wr) begin
        if (mode_r == MODE_ALLOC) begin
          alloc_cnt <= alloc_cnt + CNT_W'(1);
        end else if (alloc_cnt != '0) begin
          alloc_cnt <= alloc_cnt - CNT_W'(1);
        end
      end
      if (cmd.pos_zero) begin
        search_pos <= '0;
      end else if (cmd.wr && mode_r == MODE_ALLOC) begin
        search_pos <= BI_W'(hit_idx);
      end
    end
  end

  // result address: multiply, then add the base
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 32'(hit_idx) * 32'(block_size);
    end
    if (cmd.load) begin
      res_addr  <= 32'd0;
      res_valid <= 1'b0;
    end else if (cmd.add) begin
      res_addr  <= base_address + prod;
      res_valid <= 1'b1;
    end else if (cmd.wr && mode_r == MODE_FREE) begin
      res_valid <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.result_address  <= res_addr;
      out_data.result_valid    <= res_valid;
      out_data.allocated_total <= 9'(alloc_cnt);
    end
  end

  assign stat.mode       = mode_r;
  assign stat.n_zero     = (live_n == '0);
  assign stat.bs_zero    = (block_size == 16'd0);
  assign stat.sweep_last = (sweep_ctr == WA_W'(WORDS - 1));
  assign stat.div_last   = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign stat.idx_ok     = (CMP_W'(div_q[15:0]) < live_n);
  assign stat.hit        = hit;
  assign stat.scan_last  = phase && (scan_word == from_word);
  assign stat.out_free   = !out_valid || out_ready;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.result_valid || out_data.result_address == 32'd0))
    else $error("invalid result carries a non-zero address");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    alloc_cnt <= CNT_W'(MAX_BLOCKS))
    else $error("allocation count beyond block capacity");

  a_rmw_bit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (hit_data[hit_bit] == (mode_r == MODE_FREE)))
    else $error("bitmap write flips a bit already in the target state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (block_size != 16'd0))
    else $error("divide step with zero block size");
`endif

endmodule
`default_nettype wire
